FILE: hdl/mfps_pkg.sv
package mfps_pkg;

    // default sizing
    localparam int MAX_SIDE_DEF     = 64;
    localparam int ELEMENT_BITS_DEF = 16;

    // fixed field widths
    localparam int CFG_BITS  = 7;
    localparam int PATH_BITS = 22;
    localparam int PATH_TDW  = ((PATH_BITS + 7) / 8) * 8;

    // matrix side after reset
    localparam int SIDE_RESET = 64;

endpackage

FILE: hdl/mfps_cell.sv
module mfps_cell #(
    parameter int SUM_BITS = 23
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic                       i_insert,
    input  logic signed [SUM_BITS-1:0] i_sum,
    input  logic signed [SUM_BITS-1:0] i_next,
    output logic signed [SUM_BITS-1:0] o_val
);

    logic signed [SUM_BITS-1:0] r_val;

    // head of the line takes the fresh sum, the rest move one step down
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_insert ? i_sum : i_next;
        end
    end

    assign o_val = r_val;

endmodule

FILE: hdl/mfps_chain.sv
module mfps_chain #(
    parameter int MAX_SIDE = 64,
    parameter int SUM_BITS = 23,
    parameter int SIDE_W   = 7
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [SIDE_W-1:0]          i_head,
    input  logic signed [SUM_BITS-1:0] i_sum,
    output logic signed [SUM_BITS-1:0] o_tap0,
    output logic signed [SUM_BITS-1:0] o_tap1
);

    logic signed [SUM_BITS-1:0] w_val [MAX_SIDE+1];

    // slot past the end never reaches a used cell
    assign w_val[MAX_SIDE] = '0;

    for (genvar k = 0; k < MAX_SIDE; k++) begin : g_cell
        mfps_cell #(
            .SUM_BITS (SUM_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_shift  (i_shift),
            .i_insert (i_head == SIDE_W'(k)),
            .i_sum    (i_sum),
            .i_next   (w_val[k+1]),
            .o_val    (w_val[k])
        );
    end

    assign o_tap0 = w_val[0];
    // with a single cell the second tap is the unused end slot
    assign o_tap1 = w_val[1];

endmodule

FILE: hdl/min_falling_path_sum_top.sv
// A result is on o_m_axis_* in the cycle after the transfer of the matrix's last entry.
// Throughput: one entry per cycle; sum and three-way min are done in the accept cycle.
// Back pressure only stalls the input when the last entry arrives and the result is still held.
// Reset (i_rst_n low, synchronous): side back to 64 (clamped to MAX_SIDE), position to
// row 0 / column 0, output empty. Row cells are not cleared; the first row fills them.
module min_falling_path_sum_top #(
    parameter int MAX_SIDE     = mfps_pkg::MAX_SIDE_DEF,
    parameter int ELEMENT_BITS = mfps_pkg::ELEMENT_BITS_DEF,
    localparam int IN_TDW      = ((ELEMENT_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // matrix side register
    input  logic                          i_cfg_wr,
    input  logic [mfps_pkg::CFG_BITS-1:0] i_cfg_wdata,
    // input entries
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [IN_TDW-1:0]             i_s_axis_tdata,  // [ELEMENT_BITS-1:0] element_value
    // results
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [mfps_pkg::PATH_TDW-1:0] o_m_axis_tdata   // [21:0] path_sum, rest zero
);

    import mfps_pkg::*;

    // Sum width: one element per row plus a sign bit of headroom.
    localparam int CNT_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int SUM_BITS = ELEMENT_BITS + CNT_W + 1;
    localparam int EXT_W    = SUM_BITS + PATH_BITS;
    localparam int SIDE_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

    // ---------------------------------------------------------------
    // Side register: 0 acts as 1, values above MAX_SIDE act as MAX_SIDE.
    // Any write drops the matrix in progress.
    // ---------------------------------------------------------------
    logic [SIDE_W-1:0] r_side, n_side;
    logic [CNT_W-1:0]  r_col, r_row;
    logic              r_out_valid, n_out_valid;
    logic signed [SUM_BITS-1:0] r_left, r_best;
    logic [PATH_BITS-1:0]       r_path;

    always_comb begin
        priority if (i_cfg_wdata == '0) begin
            n_side = SIDE_W'(1);
        end else if (32'(i_cfg_wdata) > MAX_SIDE) begin
            n_side = SIDE_W'(MAX_SIDE);
        end else begin
            n_side = SIDE_W'(i_cfg_wdata);
        end
    end

    // ---------------------------------------------------------------
    // Position and handshake
    // ---------------------------------------------------------------
    logic [SIDE_W-1:0] w_head;
    logic w_last_col, w_last_row, w_last, w_accept;

    assign w_head     = r_side - SIDE_W'(1);
    assign w_last_col = (SIDE_W'(r_col) == w_head);
    assign w_last_row = (SIDE_W'(r_row) == w_head);
    assign w_last     = w_last_col && w_last_row;

    // Non-final entries go in even while a result waits.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready || !w_last;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------------------------------------------------------
    // Row store: a line of cells. The newest sum enters at cell side-1,
    // so at each entry cell 0 holds the sum straight above and cell 1
    // the one above-right; the one above-left just left cell 0.
    // ---------------------------------------------------------------
    logic signed [SUM_BITS-1:0] w_up, w_up_right, w_elem, w_min, w_sum, w_best_next;

    mfps_chain #(
        .MAX_SIDE (MAX_SIDE),
        .SUM_BITS (SUM_BITS),
        .SIDE_W   (SIDE_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_shift (w_accept),
        .i_head  (w_head),
        .i_sum   (w_sum),
        .o_tap0  (w_up),
        .o_tap1  (w_up_right)
    );

    assign w_elem = SUM_BITS'(signed'(i_s_axis_tdata[ELEMENT_BITS-1:0]));

    always_comb begin
        w_min = w_up;
        if ((r_col != '0) && (r_left < w_min)) begin
            w_min = r_left;
        end
        if (!w_last_col && (w_up_right < w_min)) begin
            w_min = w_up_right;
        end
        w_sum = (r_row == '0) ? w_elem : (w_elem + w_min);
        // first entry of the last row opens the running minimum
        w_best_next = ((r_col == '0) || (w_sum < r_best)) ? w_sum : r_best;
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    // result slot: drained on tready, refilled by the last entry in the same cycle
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept && w_last && !i_cfg_wr) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= SIDE_W'(SIDE_RST);
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_wr) begin
                r_side <= n_side;
                r_col  <= '0;
                r_row  <= '0;
            end else if (w_accept) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + CNT_W'(1);
                end else begin
                    r_col <= r_col + CNT_W'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    logic [EXT_W-1:0] w_best_ext;

    assign w_best_ext = {{PATH_BITS{w_best_next[SUM_BITS-1]}}, w_best_next};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left <= w_up;
            if (w_last_row) begin
                r_best <= w_best_next;
            end
            if (w_last && !i_cfg_wr) begin
                r_path <= w_best_ext[PATH_BITS-1:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = PATH_TDW'(r_path);

endmodule

FILE: hdl/mfps_checker.sv
module mfps_checker #(
    parameter int ELEMENT_BITS = mfps_pkg::ELEMENT_BITS_DEF,
    localparam int IN_TDW      = ((ELEMENT_BITS + 7) / 8) * 8
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_wr,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [IN_TDW-1:0]             i_s_axis_tdata,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [mfps_pkg::PATH_TDW-1:0] o_m_axis_tdata
);

    import mfps_pkg::*;

    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_valid_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_ready_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    a_cfg_no_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("result produced by side write");

endmodule

bind min_falling_path_sum_top mfps_checker #(
    .ELEMENT_BITS (ELEMENT_BITS)
) u_mfps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_wr        (i_cfg_wr),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mfps_pkg::*;

    localparam int IN_TDW      = ((ELEMENT_BITS_DEF + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off
    localparam int DRAIN_WAIT  = 3;       // result shows up in the cycle after the last entry
    localparam int RANDOM_ITEMS = 1150;   // entry count at which the random phases stop
    localparam int OVER_ITEMS   = 70;     // a bit more than one full-width row
    localparam int TAIL_ITEMS   = 30;

    localparam logic [CFG_BITS-1:0] SIDE_ZERO = 7'd0;
    localparam logic [CFG_BITS-1:0] SIDE_ONE  = 7'd1;
    localparam logic [CFG_BITS-1:0] SIDE_MAX  = 7'd64;
    localparam logic [CFG_BITS-1:0] SIDE_OVER = 7'd127;

    localparam logic [IN_TDW-1:0] ELEM_MAX = 16'h7FFF;
    localparam logic [IN_TDW-1:0] ELEM_MIN = 16'h8000;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the running min-path row and queues one expected
    // sum per completed matrix.
    // ------------------------------------------------------------------
    class path_sum_board;
        logic signed [22:0]          col_sums [MAX_SIDE_DEF];
        logic signed [22:0]          upleft;
        logic signed [22:0]          best;
        logic [CFG_BITS-1:0]         side_reg;
        int                          col;
        int                          row;
        logic signed [PATH_BITS-1:0] pending_sums [$];
        int                          errors;
        int                          sums_checked;

        function new();
            foreach (col_sums[i]) col_sums[i] = '0;
            side_reg     = CFG_BITS'(SIDE_RESET);
            errors       = 0;
            sums_checked = 0;
            restart();
        endfunction

        function void restart();
            upleft = '0;
            col    = 0;
            row    = 0;
            best   = 23'sh3FFFFF;
        endfunction

        function int side_now();
            int n;
            n = int'(side_reg);
            if (n == 0) n = 1;
            if (n > MAX_SIDE_DEF) n = MAX_SIDE_DEF;
            return n;
        endfunction

        // register write drops any matrix in progress
        function void set_side(logic [CFG_BITS-1:0] v);
            side_reg = v;
            restart();
        endfunction

        function int pending();
            return pending_sums.size();
        endfunction

        function void absorb_element(logic [IN_TDW-1:0] raw);
            int                 n;
            logic signed [22:0] elem;
            logic signed [22:0] cand;
            logic signed [22:0] sum;
            n    = side_now();
            elem = 23'(signed'(raw[ELEMENT_BITS_DEF-1:0]));
            if (col >= n) col = n - 1;
            if (row >= n) row = n - 1;
            if (row == 0) begin
                sum = elem;
            end else begin
                cand = col_sums[col];
                if (col > 0 && upleft < cand) cand = upleft;
                if (col + 1 < n && col_sums[col+1] < cand) cand = col_sums[col+1];
                sum = elem + cand;
            end
            upleft        = col_sums[col];
            col_sums[col] = sum;
            if (row == n - 1 && sum < best) best = sum;
            if (col + 1 < n) begin
                col++;
            end else begin
                col    = 0;
                upleft = '0;
                if (row + 1 < n) begin
                    row++;
                end else begin
                    pending_sums.push_back(best[PATH_BITS-1:0]);
                    restart();
                end
            end
        endfunction

        function void check_path_sum(logic [PATH_BITS-1:0] got);
            logic signed [PATH_BITS-1:0] want;
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected result, got path_sum %0d", $time, signed'(got));
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            sums_checked++;
            if (got !== want) begin
                $display("%0t: path_sum mismatch, expected %0d, actual %0d",
                         $time, want, signed'(got));
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_wr  = 1'b0;
    logic [CFG_BITS-1:0]  cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic [IN_TDW-1:0]    s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [PATH_TDW-1:0]  m_tdata;

    min_falling_path_sum_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr        (cfg_wr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),     // [15:0] element_value
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)      // [21:0] path_sum, [23:22] zero
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    path_sum_board board = new();

    int unsigned cycle_count   = 0;
    int          entries_sent  = 0;
    int          side_writes   = 0;
    int          input_stalls  = 0;
    int          burst_left    = 0;
    bit          gaps_on       = 1'b1;
    bit          hold_request  = 1'b0;

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge, pre-update values.
    // Register writes restart the predictor on the same edge as the RTL.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (cfg_wr)
                board.set_side(cfg_wdata);
            if (s_tvalid && s_tready)
                board.absorb_element(s_tdata);
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (m_tvalid && m_tready)
                board.check_path_sum(m_tdata[PATH_BITS-1:0]);
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d sums still pending",
                 CYCLE_LIMIT, board.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern in segments; on request it drops
    // tready for a long stretch so the held result backs up the input.
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int seg_len;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(5, 60);
            for (int k = 0; k < seg_len; k++) begin
                if (hold_request) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_request = 1'b0;
                end
                case (mode)
                    0:       m_tready <= 1'b1;                        // no stalls
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks. All are entered right after a rising edge.
    // ------------------------------------------------------------------

    // One entry; waits for its transfer, then maybe a gap at burst end.
    task automatic send_element(input logic [IN_TDW-1:0] v);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge i_clk); while (!s_tready);
        entries_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
                s_tvalid  <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Wait until the block has nothing in flight, then write the side.
    task automatic write_side(input logic [CFG_BITS-1:0] v);
        s_tvalid <= 1'b0;
        @(posedge i_clk);          // let the monitor see the last transfer
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        cfg_wr    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_wr    <= 1'b0;
        side_writes++;
    endtask

    function automatic logic [IN_TDW-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return ELEM_MAX;
            1:       return ELEM_MIN;
            2:       return IN_TDW'($urandom_range(0, 15));
            3:       return -IN_TDW'($urandom_range(1, 16));
            4:       return ($urandom_range(0, 1) != 0) ? '0 : '1;
            default: return IN_TDW'($urandom());
        endcase
    endfunction

    // count entries; fixed = 0 random, else every entry takes fill_value
    task automatic send_run(input int count, input bit fixed,
                            input logic [IN_TDW-1:0] fill_value);
        for (int k = 0; k < count; k++)
            send_element(fixed ? fill_value : pick_element());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int side;
        int n_mats;
        int cut;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        // Partial matrix at the reset side, then a write drops it.
        send_element(ELEM_MAX);
        send_element(ELEM_MIN);
        send_element(16'h0000);
        send_element(16'hFFFF);
        send_element(16'h0001);
        write_side(SIDE_ONE);
        // one-by-one: each entry is its own result
        send_element(ELEM_MAX);
        send_element(ELEM_MIN);
        send_element(16'h0000);
        send_element(16'hFFFF);
        // side written as zero behaves as one
        write_side(SIDE_ZERO);
        send_element(16'h5555);
        send_element(16'hAAAA);
        // 2x2 with extremes on both diagonals
        write_side(7'd2);
        send_element(ELEM_MAX);
        send_element(ELEM_MIN);
        send_element(ELEM_MIN);
        send_element(ELEM_MAX);
        // 3x3: edge columns see only two neighbors
        write_side(7'd3);
        send_element(16'd5);
        send_element(16'd1);
        send_element(16'd9);
        send_element(16'd2);
        send_element(-16'sd4);
        send_element(16'd7);
        send_element(16'd8);
        send_element(16'd3);
        send_element(-16'sd1);

        // Back-pressure: one result per entry, receiver parked, sender
        // keeps pushing with no gaps until the input stalls.
        write_side(SIDE_ONE);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        send_run(40, 1'b0, '0);
        gaps_on      = 1'b1;

        // Random phases, mostly small sides; some matrices are cut short
        // by a register write. Sides shrink so the entry budget holds.
        while (entries_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0:         side = $urandom_range(17, 32);
                1, 2, 3,
                4, 5:      side = $urandom_range(7, 16);
                default:   side = $urandom_range(1, 6);
            endcase
            while (side > 1 && entries_sent + side * side > RANDOM_ITEMS)
                side--;
            write_side(CFG_BITS'(side));
            gaps_on = ($urandom_range(0, 4) != 0);
            n_mats  = $urandom_range(1, 5);
            for (int m = 0; m < n_mats; m++) begin
                if (entries_sent + side * side > RANDOM_ITEMS)
                    break;
                if (side > 1 && $urandom_range(0, 7) == 0) begin
                    cut = $urandom_range(1, side * side - 1);
                    send_run(cut, 1'b0, '0);
                    write_side(CFG_BITS'(side));
                end else begin
                    send_run(side * side, 1'b0, '0);
                end
            end
        end

        // Full width: over-range side clamps to the maximum; the first run
        // reaches into the second row, which reads the row above. Both runs are cut
        // short, so no result may appear.
        gaps_on = 1'b1;
        write_side(SIDE_OVER);
        send_run(OVER_ITEMS, 1'b1, ELEM_MIN);
        write_side(SIDE_MAX);
        send_run(TAIL_ITEMS, 1'b1, ELEM_MAX);

        // drain
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d entries over %0d side writes, %0d path sums checked.",
                 entries_sent, side_writes, board.sums_checked);
        $display("Input was held off for %0d cycles under back-pressure.", input_stalls);
        if (board.errors == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/mfps_pkg.sv
hdl/mfps_cell.sv
hdl/mfps_chain.sv
hdl/min_falling_path_sum_top.sv
hdl/mfps_checker.sv
tb/tb_top.sv
